[design/tti_pkg.sv]
// Shared types and constants for the telemetry time interpolator.
`default_nettype none
package tti_pkg;

  // Both sample tables share one depth (navigation and acceleration).
  localparam int TBL_DEPTH = 1024;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int TBL_CW    = TBL_AW + 1;
  localparam int TIME_W    = 40;
  localparam int VAL_W     = 48;
  localparam int FRAC_W    = 16;

  // Heading circle in 1/64 degree units.
  localparam int FULL_CIRCLE     = 23040;
  localparam int HALF_CIRCLE     = 11520;
  localparam int CIRCLE_AND_HALF = 34560;

  typedef enum logic [1:0] {
    MODE_LOAD_NAV = 2'd0,
    MODE_LOAD_ACC = 2'd1,
    MODE_QUERY    = 2'd2,
    MODE_CLEAR    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NAV_EMPTY = 3'd1,
    ST_ACC_EMPTY = 3'd2,
    ST_FULL      = 3'd3,
    ST_ORDER     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    RD_NONE = 2'd0,
    RD_MID  = 2'd1,
    RD_LOM1 = 2'd2,
    RD_LO   = 2'd3
  } rd_sel_t;

  typedef enum logic [2:0] {
    LS_SPEED = 3'd0,
    LS_HEAD  = 3'd1,
    LS_LAT   = 3'd2,
    LS_LON   = 3'd3,
    LS_VERT  = 3'd4
  } lerp_sel_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_SRCH_RD, S_SRCH_CMP, S_FETCH0, S_FETCH1, S_FETCH2,
    S_DIV_INIT, S_DIV, S_LD, S_LM, S_LA, S_FIN
  } state_t;

  typedef struct packed {
    logic    load;
    logic    clr;
    logic    srch_init;
    rd_sel_t rd_sel;
    logic    div_init;
    logic    div_step;
  } tbl_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic ooo;
    logic done;
  } tbl_stat_t;

  typedef struct packed {
    logic      capture;
    tbl_cmd_t  nav;
    tbl_cmd_t  acc;
    logic      res_clear;
    logic      status_set;
    status_t   status_val;
    logic      cnt_set;
    logic      lerp_d;
    logic      lerp_m;
    logic      lerp_a;
    lerp_sel_t lerp_idx;
    logic      out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    mode_t     mode;
    tbl_stat_t nav;
    tbl_stat_t acc;
    logic      out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

[design/telemetry_time_interpolator_core.sv]
// Top level of the telemetry time interpolator.
//
// Input stream: in_tuser carries the mode (load navigation, load acceleration,
// query, clear); in_tdata carries the time and the sample fields. Every request
// gives exactly one result on the output stream, with the status in out_tuser
// and the interpolated values and navigation count in out_tdata.
// One request is worked on at a time. A load or clear passes through the
// execute and finish states before it reaches the output register. A query
// searches both tables for as many binary search steps as the larger table
// needs (at most 11 for 1024 entries, each step a registered memory read and
// a compare), then fetches the neighboring samples, runs the serial divider
// for the Q0.16 fraction and makes five passes through the shared multiplier.
// Empty-table queries finish like a load.
// The output register holds a finished result while the receiver stalls, and
// the next request is accepted meanwhile; it waits for the register only at
// its own end. Reset empties both tables by clearing their fill counts, so no
// clearing pass over the memories is needed.
`default_nettype none
module telemetry_time_interpolator_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // time_us[39:0], speed_in[55:40], heading_in[70:56], lateral_in[86:71],
  // longitudinal_in[102:87], vertical_in[118:103], zero pad[119]
  input  wire logic [119:0] in_tdata,
  // mode[1:0]
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // speed_out[15:0], heading_out[30:16], lateral_out[46:31],
  // longitudinal_out[62:47], vertical_out[78:63], explored_count[89:79],
  // zero pad[95:90]
  output logic [95:0]       out_tdata,
  // status[2:0]
  output logic [2:0]        out_tuser
);

  tti_pkg::ctrl_cmd_t cmd;
  tti_pkg::dp_stat_t  stat;
  logic [15:0]        speed_o, lat_o, lon_o, vert_o;
  logic [14:0]        head_o;
  logic [10:0]        cnt_o;

  tti_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tti_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_mode     (in_tuser),
    .in_time     (in_tdata[39:0]),
    .in_speed    (in_tdata[55:40]),
    .in_heading  (in_tdata[70:56]),
    .in_lat      (in_tdata[86:71]),
    .in_lon      (in_tdata[102:87]),
    .in_vert     (in_tdata[118:103]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_status  (out_tuser),
    .out_speed   (speed_o),
    .out_heading (head_o),
    .out_lat     (lat_o),
    .out_lon     (lon_o),
    .out_vert    (vert_o),
    .out_count   (cnt_o)
  );

  assign out_tdata = {6'd0, cnt_o, vert_o, lon_o, lat_o, head_o, speed_o};

endmodule
`default_nettype wire

[design/tti_ram.sv]
// Generic single-port RAM with registered read data.
`default_nettype none
module tti_ram #(
  parameter int DW    = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [DW-1:0]            wdata,
  output logic      [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

[design/tti_tbl.sv]
// One sample table: storage, fill tracking, binary search and fraction divider.
`default_nettype none
module tti_tbl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire tti_pkg::tbl_cmd_t             cmd,
  input  wire logic [tti_pkg::TIME_W-1:0]    time_in,
  input  wire logic [tti_pkg::VAL_W-1:0]     data_in,
  output tti_pkg::tbl_stat_t                 stat,
  output logic      [tti_pkg::VAL_W-1:0]     v0,
  output logic      [tti_pkg::VAL_W-1:0]     v1,
  output logic                               ep,
  output logic      [tti_pkg::FRAC_W-1:0]    frac,
  output logic      [tti_pkg::TBL_CW-1:0]    count
);

  logic [tti_pkg::TBL_CW-1:0]  fill_r, lo_r, hi_r, mid_r;
  logic [tti_pkg::TIME_W-1:0]  last_r, t0_r, t1_r, rem_r, span_r;
  logic [tti_pkg::VAL_W-1:0]   v0_r, v1_r;
  logic [tti_pkg::FRAC_W-1:0]  q_r;
  tti_pkg::rd_sel_t            sel_r;

  logic [tti_pkg::TBL_AW-1:0]  addr;
  logic [tti_pkg::TBL_CW:0]    mid_sum;
  logic [tti_pkg::TBL_CW-1:0]  mid_w;
  logic [tti_pkg::TIME_W-1:0]  t_rd;
  logic [tti_pkg::VAL_W-1:0]   v_rd;
  logic [tti_pkg::TIME_W:0]    rem2;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_w   = mid_sum[tti_pkg::TBL_CW:1];
  assign rem2    = {rem_r, 1'b0};

  always_comb begin
    if (cmd.load) begin
      addr = fill_r[tti_pkg::TBL_AW-1:0];
    end else begin
      case (cmd.rd_sel)
        tti_pkg::RD_MID:  addr = mid_w[tti_pkg::TBL_AW-1:0];
        tti_pkg::RD_LOM1: begin
          if (lo_r == '0) begin
            addr = '0;
          end else begin
            addr = tti_pkg::TBL_AW'(lo_r - tti_pkg::TBL_CW'(1));
          end
        end
        tti_pkg::RD_LO:   addr = lo_r[tti_pkg::TBL_AW-1:0];
        default:          addr = '0;
      endcase
    end
  end

  tti_ram #(.DW(tti_pkg::TIME_W), .DEPTH(tti_pkg::TBL_DEPTH)) u_time_ram (
    .clk   (clk),
    .we    (cmd.load),
    .addr  (addr),
    .wdata (time_in),
    .rdata (t_rd)
  );

  tti_ram #(.DW(tti_pkg::VAL_W), .DEPTH(tti_pkg::TBL_DEPTH)) u_val_ram (
    .clk   (clk),
    .we    (cmd.load),
    .addr  (addr),
    .wdata (data_in),
    .rdata (v_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      lo_r   <= '0;
      hi_r   <= '0;
      sel_r  <= tti_pkg::RD_NONE;
    end else begin
      sel_r <= cmd.rd_sel;
      if (cmd.clr) begin
        fill_r <= '0;
      end else if (cmd.load) begin
        fill_r <= fill_r + tti_pkg::TBL_CW'(1);
      end
      if (cmd.srch_init) begin
        lo_r <= '0;
        hi_r <= fill_r;
      end else if (sel_r == tti_pkg::RD_MID && lo_r < hi_r) begin
        // Upper-bound search: keep the first entry later than the query time.
        if (time_in < t_rd) begin
          hi_r <= mid_r;
        end else begin
          lo_r <= mid_r + tti_pkg::TBL_CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      last_r <= time_in;
    end
    if (cmd.rd_sel == tti_pkg::RD_MID) begin
      mid_r <= mid_w;
    end
    if (sel_r == tti_pkg::RD_LOM1) begin
      t0_r <= t_rd;
      v0_r <= v_rd;
    end
    if (sel_r == tti_pkg::RD_LO) begin
      t1_r <= t_rd;
      v1_r <= v_rd;
    end
    if (cmd.div_init) begin
      rem_r  <= time_in - t0_r;
      span_r <= t1_r - t0_r;
      q_r    <= '0;
    end else if (cmd.div_step) begin
      // Restoring division, one quotient bit per cycle.
      if (rem2 >= {1'b0, span_r}) begin
        rem_r <= tti_pkg::TIME_W'(rem2 - {1'b0, span_r});
        q_r   <= {q_r[tti_pkg::FRAC_W-2:0], 1'b1};
      end else begin
        rem_r <= rem2[tti_pkg::TIME_W-1:0];
        q_r   <= {q_r[tti_pkg::FRAC_W-2:0], 1'b0};
      end
    end
  end

  assign ep         = (lo_r == '0) || (lo_r >= fill_r);
  assign frac       = ep ? '0 : q_r;
  assign v0         = v0_r;
  assign v1         = v1_r;
  assign count      = lo_r;
  assign stat.empty = (fill_r == '0);
  assign stat.full  = (fill_r >= tti_pkg::TBL_CW'(tti_pkg::TBL_DEPTH));
  assign stat.ooo   = (fill_r != '0) && (time_in < last_r);
  assign stat.done  = (lo_r >= hi_r);

endmodule
`default_nettype wire

[design/tti_dp.sv]
// Datapath: input latch, both tables, shared interpolation multiplier, result registers.
`default_nettype none
module tti_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tti_pkg::ctrl_cmd_t cmd,
  output tti_pkg::dp_stat_t       stat,
  input  wire logic [1:0]         in_mode,
  input  wire logic [39:0]        in_time,
  input  wire logic [15:0]        in_speed,
  input  wire logic [14:0]        in_heading,
  input  wire logic [15:0]        in_lat,
  input  wire logic [15:0]        in_lon,
  input  wire logic [15:0]        in_vert,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_status,
  output logic [15:0]             out_speed,
  output logic [14:0]             out_heading,
  output logic [15:0]             out_lat,
  output logic [15:0]             out_lon,
  output logic [15:0]             out_vert,
  output logic [10:0]             out_count
);

  tti_pkg::mode_t mode_r;
  logic [39:0]    time_r;
  logic [15:0]    speed_r, lat_r, lon_r, vert_r;
  logic [14:0]    heading_r;

  logic [tti_pkg::VAL_W-1:0]  nav_v0, nav_v1, acc_v0, acc_v1;
  logic                       nav_ep, acc_ep;
  logic [tti_pkg::FRAC_W-1:0] nav_frac, acc_frac;
  logic [tti_pkg::TBL_CW-1:0] nav_cnt, acc_cnt;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r    <= tti_pkg::mode_t'(in_mode);
      time_r    <= in_time;
      speed_r   <= in_speed;
      heading_r <= in_heading;
      lat_r     <= in_lat;
      lon_r     <= in_lon;
      vert_r    <= in_vert;
    end
  end

  tti_tbl u_nav (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd.nav),
    .time_in (time_r),
    .data_in ({17'd0, heading_r, speed_r}),
    .stat    (stat.nav),
    .v0      (nav_v0),
    .v1      (nav_v1),
    .ep      (nav_ep),
    .frac    (nav_frac),
    .count   (nav_cnt)
  );

  tti_tbl u_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd.acc),
    .time_in (time_r),
    .data_in ({vert_r, lon_r, lat_r}),
    .stat    (stat.acc),
    .v0      (acc_v0),
    .v1      (acc_v1),
    .ep      (acc_ep),
    .frac    (acc_frac),
    .count   (acc_cnt)
  );

  // Operand selection for the shared interpolation unit.
  logic [17:0]        ha, hb, hs, hs1, hs2;
  logic signed [17:0] a_w, d_w;
  logic [15:0]        f_w;
  logic [15:0]        sa, sb;

  assign ha = {3'd0, nav_v0[30:16]};
  assign hb = {3'd0, nav_v1[30:16]};
  // The true value of hs is always positive; modular wrap of hb - ha is harmless.
  assign hs  = hb - ha + 18'(tti_pkg::CIRCLE_AND_HALF);
  assign hs1 = (hs >= 18'(tti_pkg::FULL_CIRCLE)) ? hs - 18'(tti_pkg::FULL_CIRCLE) : hs;
  assign hs2 = (hs1 >= 18'(tti_pkg::FULL_CIRCLE)) ? hs1 - 18'(tti_pkg::FULL_CIRCLE) : hs1;

  always_comb begin
    sa  = acc_v0[15:0];
    sb  = acc_v1[15:0];
    f_w = acc_frac;
    case (cmd.lerp_idx)
      tti_pkg::LS_LON: begin
        sa = acc_v0[31:16];
        sb = acc_v1[31:16];
      end
      tti_pkg::LS_VERT: begin
        sa = acc_v0[47:32];
        sb = acc_v1[47:32];
      end
      default: begin
      end
    endcase
    case (cmd.lerp_idx)
      tti_pkg::LS_SPEED: begin
        a_w = $signed({2'd0, nav_v0[15:0]});
        d_w = $signed({2'd0, nav_v1[15:0]}) - a_w;
        f_w = nav_frac;
      end
      tti_pkg::LS_HEAD: begin
        a_w = $signed(ha);
        d_w = $signed(hs2 - 18'(tti_pkg::HALF_CIRCLE));
        f_w = nav_frac;
      end
      default: begin
        a_w = $signed({{2{sa[15]}}, sa});
        d_w = $signed({{2{sb[15]}}, sb}) - a_w;
      end
    endcase
  end

  logic signed [17:0] d_r, a_r;
  logic [15:0]        f_r;
  logic signed [34:0] prod_r;
  logic [18:0]        sum_w, hw;

  always_ff @(posedge clk) begin
    if (cmd.lerp_d) begin
      d_r <= d_w;
      a_r <= a_w;
      f_r <= f_w;
    end
    if (cmd.lerp_m) begin
      prod_r <= d_r * $signed({1'b0, f_r});
    end
  end

  // Arithmetic shift of the product floors toward minus infinity.
  assign sum_w = {a_r[17], a_r} + prod_r[34:16];

  always_comb begin
    if (sum_w[18]) begin
      hw = sum_w + 19'(tti_pkg::FULL_CIRCLE);
    end else if (sum_w >= 19'(tti_pkg::FULL_CIRCLE)) begin
      hw = sum_w - 19'(tti_pkg::FULL_CIRCLE);
    end else begin
      hw = sum_w;
    end
  end

  // Result staging and output registers.
  logic [2:0]  res_status_r;
  logic [15:0] res_speed_r, res_lat_r, res_lon_r, res_vert_r;
  logic [14:0] res_head_r;
  logic [10:0] res_cnt_r;
  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [15:0] out_speed_r, out_lat_r, out_lon_r, out_vert_r;
  logic [14:0] out_head_r;
  logic [10:0] out_cnt_r;

  always_ff @(posedge clk) begin
    if (cmd.res_clear) begin
      res_speed_r <= '0;
      res_head_r  <= '0;
      res_lat_r   <= '0;
      res_lon_r   <= '0;
      res_vert_r  <= '0;
      res_cnt_r   <= '0;
    end else begin
      if (cmd.cnt_set) begin
        res_cnt_r <= nav_cnt[10:0];
      end
      if (cmd.lerp_a) begin
        case (cmd.lerp_idx)
          tti_pkg::LS_SPEED: res_speed_r <= sum_w[15:0];
          tti_pkg::LS_HEAD:  res_head_r  <= nav_ep ? nav_v0[30:16] : hw[14:0];
          tti_pkg::LS_LAT:   res_lat_r   <= sum_w[15:0];
          tti_pkg::LS_LON:   res_lon_r   <= sum_w[15:0];
          tti_pkg::LS_VERT:  res_vert_r  <= sum_w[15:0];
          default: begin
          end
        endcase
      end
    end
    if (cmd.status_set) begin
      res_status_r <= cmd.status_val;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_speed_r  <= res_speed_r;
      out_head_r   <= res_head_r;
      out_lat_r    <= res_lat_r;
      out_lon_r    <= res_lon_r;
      out_vert_r   <= res_vert_r;
      out_cnt_r    <= res_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.mode     = mode_r;
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_speed   = out_speed_r;
  assign out_heading = out_head_r;
  assign out_lat     = out_lat_r;
  assign out_lon     = out_lon_r;
  assign out_vert    = out_vert_r;
  assign out_count   = out_cnt_r;

endmodule
`default_nettype wire

[design/tti_ctrl.sv]
// Controller state machine that sequences loads, searches, division and interpolation.
`default_nettype none
module tti_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire tti_pkg::dp_stat_t stat,
  output tti_pkg::ctrl_cmd_t     cmd
);

  tti_pkg::state_t    state_r, state_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  tti_pkg::lerp_sel_t idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tti_pkg::S_IDLE;
      cnt_r   <= '0;
      idx_r   <= tti_pkg::LS_SPEED;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.lerp_idx = idx_r;
    case (state_r)
      tti_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = tti_pkg::S_EXEC;
        end
      end
      tti_pkg::S_EXEC: begin
        cmd.res_clear  = 1'b1;
        cmd.status_set = 1'b1;
        cmd.status_val = tti_pkg::ST_OK;
        state_nxt      = tti_pkg::S_FIN;
        case (stat.mode)
          tti_pkg::MODE_LOAD_NAV: begin
            if (stat.nav.full) begin
              cmd.status_val = tti_pkg::ST_FULL;
            end else if (stat.nav.ooo) begin
              cmd.status_val = tti_pkg::ST_ORDER;
            end else begin
              cmd.nav.load = 1'b1;
            end
          end
          tti_pkg::MODE_LOAD_ACC: begin
            if (stat.acc.full) begin
              cmd.status_val = tti_pkg::ST_FULL;
            end else if (stat.acc.ooo) begin
              cmd.status_val = tti_pkg::ST_ORDER;
            end else begin
              cmd.acc.load = 1'b1;
            end
          end
          tti_pkg::MODE_CLEAR: begin
            cmd.nav.clr = 1'b1;
            cmd.acc.clr = 1'b1;
          end
          default: begin
            if (stat.nav.empty) begin
              cmd.status_val = tti_pkg::ST_NAV_EMPTY;
            end else if (stat.acc.empty) begin
              cmd.status_val = tti_pkg::ST_ACC_EMPTY;
            end else begin
              cmd.nav.srch_init = 1'b1;
              cmd.acc.srch_init = 1'b1;
              state_nxt         = tti_pkg::S_SRCH_RD;
            end
          end
        endcase
      end
      tti_pkg::S_SRCH_RD: begin
        // Both searches step together; a finished one ignores further steps.
        if (stat.nav.done && stat.acc.done) begin
          state_nxt = tti_pkg::S_FETCH0;
        end else begin
          cmd.nav.rd_sel = tti_pkg::RD_MID;
          cmd.acc.rd_sel = tti_pkg::RD_MID;
          state_nxt      = tti_pkg::S_SRCH_CMP;
        end
      end
      tti_pkg::S_SRCH_CMP: begin
        state_nxt = tti_pkg::S_SRCH_RD;
      end
      tti_pkg::S_FETCH0: begin
        cmd.nav.rd_sel = tti_pkg::RD_LOM1;
        cmd.acc.rd_sel = tti_pkg::RD_LOM1;
        state_nxt      = tti_pkg::S_FETCH1;
      end
      tti_pkg::S_FETCH1: begin
        cmd.nav.rd_sel = tti_pkg::RD_LO;
        cmd.acc.rd_sel = tti_pkg::RD_LO;
        state_nxt      = tti_pkg::S_FETCH2;
      end
      tti_pkg::S_FETCH2: begin
        state_nxt = tti_pkg::S_DIV_INIT;
      end
      tti_pkg::S_DIV_INIT: begin
        cmd.nav.div_init = 1'b1;
        cmd.acc.div_init = 1'b1;
        cnt_nxt          = '0;
        state_nxt        = tti_pkg::S_DIV;
      end
      tti_pkg::S_DIV: begin
        cmd.nav.div_step = 1'b1;
        cmd.acc.div_step = 1'b1;
        cnt_nxt          = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          idx_nxt   = tti_pkg::LS_SPEED;
          state_nxt = tti_pkg::S_LD;
        end
      end
      tti_pkg::S_LD: begin
        cmd.lerp_d = 1'b1;
        state_nxt  = tti_pkg::S_LM;
      end
      tti_pkg::S_LM: begin
        cmd.lerp_m = 1'b1;
        state_nxt  = tti_pkg::S_LA;
      end
      tti_pkg::S_LA: begin
        cmd.lerp_a  = 1'b1;
        cmd.cnt_set = 1'b1;
        if (idx_r == tti_pkg::LS_VERT) begin
          state_nxt = tti_pkg::S_FIN;
        end else begin
          idx_nxt   = tti_pkg::lerp_sel_t'(idx_r + 3'd1);
          state_nxt = tti_pkg::S_LD;
        end
      end
      tti_pkg::S_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = tti_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tti_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire
